### sv/lfct_pkg.sv
// ----------------------------------------------------------------------------
// lfct_pkg: shared types, codes and helpers of the local frame transform.
// Holds the word types, mode and result codes, and the rounding functions.
// ----------------------------------------------------------------------------
`default_nettype none

package lfct_pkg;

    typedef logic signed [31:0] t_word;
    typedef logic signed [63:0] t_wide;
    typedef logic signed [35:0] t_rnd;

    localparam int AXIS_FRAC = 30;
    localparam t_word AXIS_ONE = 32'sh4000_0000;

    localparam logic [1:0] MODE_ORG = 2'd0;
    localparam logic [1:0] MODE_SEC = 2'd1;
    localparam logic [1:0] MODE_REF = 2'd2;
    localparam logic [1:0] MODE_XF  = 2'd3;

    localparam logic KIND_AXIS  = 1'b0;
    localparam logic KIND_LOCAL = 1'b1;
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_DEGEN   = 1'b1;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    // Round to nearest at the axis fraction, ties away from zero.
    function automatic t_rnd rnd30(input t_wide v);
        logic [63:0] m;
        logic [63:0] r;
        m = v[63] ? 64'(-v) : 64'(v);
        r = (m + (64'd1 << (AXIS_FRAC - 1))) >> AXIS_FRAC;
        return v[63] ? -$signed(r[35:0]) : $signed(r[35:0]);
    endfunction

    function automatic t_word sat32(input t_rnd v);
        if (v > 36'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -36'sh0_8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic t_word clamp_axis(input t_rnd v);
        if (v > 36'(AXIS_ONE)) return AXIS_ONE;
        if (v < -36'(AXIS_ONE)) return -AXIS_ONE;
        return v[31:0];
    endfunction

    function automatic logic [62:0] mag63(input t_wide v);
        t_wide t;
        t = v[63] ? -v : v;
        return t[62:0];
    endfunction

    // Cross product operand order: u1v2, u2v1, u2v0, u0v2, u0v1, u1v0.
    function automatic logic [1:0] xa(input logic [2:0] k);
        case (k)
            3'd0: return 2'd1;
            3'd1: return 2'd2;
            3'd2: return 2'd2;
            3'd5: return 2'd1;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] xb(input logic [2:0] k);
        case (k)
            3'd0: return 2'd2;
            3'd1: return 2'd1;
            3'd3: return 2'd2;
            3'd4: return 2'd1;
            default: return 2'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

### sv/lfct_mul.sv
// ----------------------------------------------------------------------------
// lfct_mul: shared signed multiplier
// One 32 by 32 signed product per cycle, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lfct_mul import lfct_pkg::*; (
    input  wire logic  i_clk,
    input  wire t_word i_a,
    input  wire t_word i_b,
    output t_wide      o_p
);

    t_wide w_p;
    t_wide r_p;

    assign w_p = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_p <= w_p;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

### sv/lfct_sqrt.sv
// ----------------------------------------------------------------------------
// lfct_sqrt: iterative integer square root
// Bitwise floor square root of a 64-bit value, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfct_sqrt import lfct_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_x,
    output logic             o_done,
    output logic [30:0]      o_root
);

    logic [63:0] r_x;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [63:0] w_t;

    assign w_t = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_x;
                r_res  <= '0;
                r_bit  <= 64'd1 << 62;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_x >= w_t) begin
                    r_x   <= r_x - w_t;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(SQRT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[30:0];

endmodule

`default_nettype wire

### sv/lfct_div.sv
// ----------------------------------------------------------------------------
// lfct_div: iterative restoring divider
// Produces a 31-bit quotient, one bit per cycle; the high dividend part
// must already be below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module lfct_div import lfct_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [30:0] i_hi,
    input  wire logic [30:0] i_lo,
    input  wire logic [30:0] i_den,
    output logic             o_done,
    output logic [30:0]      o_quo
);

    logic [30:0] r_rem;
    logic [30:0] r_lo;
    logic [30:0] r_den;
    logic [30:0] r_q;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [31:0] w_t;
    logic        w_ge;

    assign w_t  = {r_rem, r_lo[30]};
    assign w_ge = w_t >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_hi;
                r_lo   <= i_lo;
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? 31'(w_t - {1'b0, r_den}) : w_t[30:0];
                r_lo  <= r_lo << 1;
                r_q   <= {r_q[29:0], w_ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

`default_nettype wire

### sv/local_frame_coordinate_transform_top.sv
// ----------------------------------------------------------------------------
// local_frame_coordinate_transform_top: three-point local frame transform
// Builds an orthonormal frame from three points and maps atoms into it.
// ----------------------------------------------------------------------------
// Each input transaction carries a mode and a Q16.16 point. Modes 0 and 1 load
// the origin and the second point and give no result. Mode 3 transforms an
// atom: nine products go through the one shared multiplier, and the next
// transaction can be accepted once the result has gone into the output
// register, which waits until that register is free. Mode 2 builds a new
// frame and returns its rows i, j and k as three transactions, the last one
// flagged. The build is sequenced over the multiplier, a bit-serial square
// root and a bit-serial divider: block scaling shifts each vector into range,
// and each unit vector costs 3 products, 32 root steps and three 31-step
// divisions. If the reference or second point equals the origin, or the
// points are collinear, the old frame is kept and its rows are returned with
// status set. The input is not ready while an item is being worked on; a
// finished result sits in the output register and does not hold up the next
// load.
// ----------------------------------------------------------------------------
`default_nettype none

module local_frame_coordinate_transform_top import lfct_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_mode,
    input  wire t_word       i_px,
    input  wire t_word       i_py,
    input  wire t_word       i_pz,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_kind,
    output t_word            o_qx,
    output t_word            o_qy,
    output t_word            o_qz,
    output logic             o_last,
    output logic             o_status
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCALE  = 4'd1;
    localparam logic [3:0] S_CROSS  = 4'd2;
    localparam logic [3:0] S_SQ     = 4'd3;
    localparam logic [3:0] S_SQRT   = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_COMMIT = 4'd6;
    localparam logic [3:0] S_EMIT   = 4'd7;
    localparam logic [3:0] S_XF     = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    localparam logic [1:0] VS_A  = 2'd0;
    localparam logic [1:0] VS_B  = 2'd1;
    localparam logic [1:0] VS_CR = 2'd2;

    logic [3:0]         r_state;
    t_word              r_org [3];
    t_word              r_sec [3];
    t_word              r_frm [3][3];
    logic signed [32:0] r_bd [3];
    logic [62:0]        r_m [3];
    logic [2:0]         r_sg;
    logic [1:0]         r_vsel;
    logic signed [30:0] r_as [3];
    logic signed [30:0] r_bs [3];
    t_wide              r_cr [3];
    t_word              r_kq [3];
    t_word              r_jq [3];
    t_word              r_iq [3];
    logic               r_unit;
    logic               r_xsel;
    logic               r_deg;
    logic [30:0]        r_len;
    logic [1:0]         r_c;
    logic [2:0]         r_cnt;
    logic [2:0]         r_dk;
    logic               r_dv;
    logic [1:0]         r_row;
    logic [1:0]         r_col;
    logic [1:0]         r_drow;
    logic [1:0]         r_dcol;
    t_word              r_d [3];
    t_word              r_res [3];
    t_wide              r_acc;
    logic               r_ovalid;
    logic               r_okind;
    t_word              r_oq [3];
    logic               r_olast;
    logic               r_ostat;

    t_word              w_p [3];
    logic signed [32:0] w_a [3];
    logic signed [32:0] w_b [3];
    logic signed [32:0] w_dx [3];
    logic [62:0]        w_or;
    t_word              w_ma;
    t_word              w_mb;
    t_wide              w_prod;
    t_wide              w_sum;
    t_wide              w_dif;
    logic               w_out_free;
    logic               w_accept;
    logic               w_sqrt_start;
    logic               w_sqrt_done;
    logic [30:0]        w_root;
    logic               w_div_start;
    logic               w_div_done;
    logic [30:0]        w_quo;
    logic [1:0]         w_dc;
    t_word              w_qs;

    assign w_p[0] = i_px;
    assign w_p[1] = i_py;
    assign w_p[2] = i_pz;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_a[c]  = {w_p[c][31], w_p[c]} - {r_org[c][31], r_org[c]};
            w_b[c]  = {r_sec[c][31], r_sec[c]} - {r_org[c][31], r_org[c]};
            w_dx[c] = w_a[c];
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_ovalid || i_ready;
    assign w_or       = r_m[0] | r_m[1] | r_m[2];

    // Operand selection for the shared multiplier.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_CROSS: begin
                if (r_xsel) begin
                    w_ma = r_jq[xa(r_cnt)];
                    w_mb = r_kq[xb(r_cnt)];
                end else begin
                    w_ma = {r_as[xa(r_cnt)][30], r_as[xa(r_cnt)]};
                    w_mb = {r_bs[xb(r_cnt)][30], r_bs[xb(r_cnt)]};
                end
            end
            S_SQ: begin
                case (r_cnt)
                    3'd0: w_ma = r_m[0][31:0];
                    3'd1: w_ma = r_m[1][31:0];
                    3'd2: w_ma = r_m[2][31:0];
                    default: w_ma = '0;
                endcase
                w_mb = w_ma;
            end
            S_XF: begin
                w_ma = r_frm[r_row][r_col];
                w_mb = r_d[r_col];
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    lfct_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    assign w_sum = r_acc + w_prod;
    assign w_dif = r_acc - w_prod;

    assign w_sqrt_start = (r_state == S_SQ) && r_dv && (r_dk == 3'd2);

    lfct_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_x     (64'(w_sum)),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    assign w_div_start = ((r_state == S_SQRT) && w_sqrt_done) ||
                         ((r_state == S_DIV) && w_div_done && (r_c != 2'd2));
    assign w_dc = (r_state == S_SQRT) ? 2'd0 :
                  ((r_c == 2'd2) ? 2'd0 : 2'(r_c + 2'd1));

    lfct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_hi    ({2'b00, r_m[w_dc][29:1]}),
        .i_lo    ({r_m[w_dc][0], 30'd0}),
        .i_den   ((r_state == S_SQRT) ? w_root : r_len),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_qs = r_sg[r_c] ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_dv     <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                r_org[r] <= '0;
                r_sec[r] <= '0;
                for (int c = 0; c < 3; c++) begin
                    r_frm[r][c] <= (r == c) ? AXIS_ONE : '0;
                end
            end
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            r_dk   <= r_cnt;
            r_drow <= r_row;
            r_dcol <= r_col;
            r_dv   <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_mode)
                            MODE_ORG: begin
                                for (int c = 0; c < 3; c++) r_org[c] <= w_p[c];
                            end
                            MODE_SEC: begin
                                for (int c = 0; c < 3; c++) r_sec[c] <= w_p[c];
                            end
                            MODE_REF: begin
                                for (int c = 0; c < 3; c++) begin
                                    r_m[c]  <= mag63(64'(w_a[c]));
                                    r_sg[c] <= w_a[c][32];
                                    r_bd[c] <= w_b[c];
                                end
                                r_vsel  <= VS_A;
                                r_deg   <= 1'b0;
                                r_state <= S_SCALE;
                            end
                            default: begin
                                for (int c = 0; c < 3; c++) begin
                                    r_d[c] <= sat32(36'(w_dx[c]));
                                end
                                r_row   <= '0;
                                r_col   <= '0;
                                r_state <= S_XF;
                            end
                        endcase
                    end
                end

                // Block scaling: one bit of shift per cycle until the largest
                // magnitude has its top bit at position 29; an all-zero vector is degenerate.
                S_SCALE: begin
                    r_cnt <= '0;
                    if (w_or == '0) begin
                        r_deg   <= 1'b1;
                        r_row   <= '0;
                        r_state <= S_EMIT;
                    end else if (|w_or[62:30]) begin
                        for (int c = 0; c < 3; c++) r_m[c] <= r_m[c] >> 1;
                    end else if (!w_or[29]) begin
                        for (int c = 0; c < 3; c++) r_m[c] <= r_m[c] << 1;
                    end else begin
                        case (r_vsel)
                            VS_A: begin
                                for (int c = 0; c < 3; c++) begin
                                    r_as[c] <= r_sg[c] ? -$signed({1'b0, r_m[c][29:0]})
                                                       : $signed({1'b0, r_m[c][29:0]});
                                    r_m[c]  <= mag63(64'(r_bd[c]));
                                    r_sg[c] <= r_bd[c][32];
                                end
                                r_vsel <= VS_B;
                            end
                            VS_B: begin
                                for (int c = 0; c < 3; c++) begin
                                    r_bs[c] <= r_sg[c] ? -$signed({1'b0, r_m[c][29:0]})
                                                       : $signed({1'b0, r_m[c][29:0]});
                                end
                                r_xsel  <= 1'b0;
                                r_state <= S_CROSS;
                            end
                            default: begin
                                r_unit  <= 1'b1;
                                r_state <= S_SQ;
                            end
                        endcase
                    end
                end

                // Cross product: even steps load a product, odd steps subtract.
                S_CROSS: begin
                    r_cnt <= r_cnt + 3'd1;
                    r_dv  <= 1'b1;
                    if (r_dv) begin
                        if (!r_dk[0]) begin
                            r_acc <= w_prod;
                        end else if (r_xsel) begin
                            r_iq[r_dk[2:1]] <= clamp_axis(rnd30(w_dif));
                        end else begin
                            r_cr[r_dk[2:1]] <= w_dif;
                        end
                        if (r_dk == 3'd5) begin
                            r_dv  <= 1'b0;
                            r_cnt <= '0;
                            if (r_xsel) begin
                                r_state <= S_COMMIT;
                            end else begin
                                for (int c = 0; c < 3; c++) begin
                                    r_m[c]  <= mag63(64'(r_as[c]));
                                    r_sg[c] <= r_as[c][30];
                                end
                                r_unit  <= 1'b0;
                                r_state <= S_SQ;
                            end
                        end
                    end
                end

                S_SQ: begin
                    r_cnt <= r_cnt + 3'd1;
                    r_dv  <= 1'b1;
                    if (r_dv) begin
                        r_acc <= (r_dk == 3'd0) ? w_prod : w_sum;
                        if (r_dk == 3'd2) begin
                            r_dv    <= 1'b0;
                            r_state <= S_SQRT;
                        end
                    end
                end

                S_SQRT: begin
                    if (w_sqrt_done) begin
                        r_len   <= w_root;
                        r_c     <= '0;
                        r_state <= S_DIV;
                    end
                end

                S_DIV: begin
                    if (w_div_done) begin
                        if (r_unit) r_jq[r_c] <= w_qs;
                        else        r_kq[r_c] <= w_qs;
                        if (r_c != 2'd2) begin
                            r_c <= r_c + 2'd1;
                        end else if (r_unit) begin
                            r_cnt   <= '0;
                            r_xsel  <= 1'b1;
                            r_state <= S_CROSS;
                        end else begin
                            for (int c = 0; c < 3; c++) begin
                                r_m[c]  <= mag63(r_cr[c]);
                                r_sg[c] <= r_cr[c][63];
                            end
                            r_vsel  <= VS_CR;
                            r_state <= S_SCALE;
                        end
                    end
                end

                S_COMMIT: begin
                    for (int c = 0; c < 3; c++) begin
                        r_frm[0][c] <= r_iq[c];
                        r_frm[1][c] <= r_jq[c];
                        r_frm[2][c] <= r_kq[c];
                    end
                    r_row   <= '0;
                    r_state <= S_EMIT;
                end

                S_EMIT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_AXIS;
                        for (int c = 0; c < 3; c++) r_oq[c] <= r_frm[r_row][c];
                        r_olast  <= (r_row == 2'd2);
                        r_ostat  <= r_deg ? ST_DEGEN : ST_OK;
                        r_row    <= r_row + 2'd1;
                        if (r_row == 2'd2) begin
                            r_state <= S_IDLE;
                        end
                    end
                end

                // Atom transform: row by row, three products per row.
                S_XF: begin
                    r_dv <= 1'b1;
                    if (r_col == 2'd2) begin
                        if (r_row != 2'd2) begin
                            r_col <= '0;
                            r_row <= r_row + 2'd1;
                        end
                    end else begin
                        r_col <= r_col + 2'd1;
                    end
                    if (r_dv) begin
                        if (r_dcol == 2'd0) begin
                            r_acc <= w_prod;
                        end else begin
                            r_acc <= w_sum;
                        end
                        if (r_dcol == 2'd2) begin
                            r_res[r_drow] <= sat32(rnd30(w_sum));
                            if (r_drow == 2'd2) begin
                                r_dv    <= 1'b0;
                                r_state <= S_OUT;
                            end
                        end
                    end
                end

                S_OUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_LOCAL;
                        for (int c = 0; c < 3; c++) r_oq[c] <= r_res[c];
                        r_olast  <= 1'b1;
                        r_ostat  <= ST_OK;
                        r_state  <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_ovalid;
    assign o_kind   = r_okind;
    assign o_qx     = r_oq[0];
    assign o_qy     = r_oq[1];
    assign o_qz     = r_oq[2];
    assign o_last   = r_olast;
    assign o_status = r_ostat;

`ifndef ASSERT_OFF
    // Local coordinates never carry the degenerate status.
    a_local_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_LOCAL) |-> (o_status == ST_OK))
        else $error("local result with degenerate status");

    // The x component of the k axis always stays unit-bounded in Q2.30.
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frm[2][0] <= AXIS_ONE) && (r_frm[2][0] >= -AXIS_ONE))
        else $error("frame component out of range");

    // A build or an atom keeps the input busy on the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_mode == MODE_REF || i_mode == MODE_XF)) |=> !o_ready)
        else $error("input ready while item in flight");
`endif

endmodule

`default_nettype wire
